[sv/alternating_bit_arq_sender_assert.svh]
// Assertion macros for the alternating-bit ARQ sender
`ifndef ALTERNATING_BIT_ARQ_SENDER_ASSERT_SVH
`define ALTERNATING_BIT_ARQ_SENDER_ASSERT_SVH

// same-cycle implication
`define ABARQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ABARQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/abarq_pkg.sv]
// Package: codes, widths and reset values of the alternating-bit ARQ sender
package abarq_pkg;

	localparam int unsigned TimeoutW = 16;
	localparam int unsigned AttemptW = 4;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned KindW    = 2;

	localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
	localparam logic [AttemptW-1:0] AttemptsReset = 4'd5;
	localparam logic [TimeoutW-1:0] TimerMax = 16'hFFFF;

	// request kinds (s_tuser)
	localparam logic [KindW-1:0] REQ_START = 2'd0;
	localparam logic [KindW-1:0] REQ_ACK   = 2'd1;
	localparam logic [KindW-1:0] REQ_TICK  = 2'd2;

	// event kinds (m_tuser)
	localparam logic [KindW-1:0] EV_TRANSMIT  = 2'd0;
	localparam logic [KindW-1:0] EV_DELIVERED = 2'd1;
	localparam logic [KindW-1:0] EV_FAILED    = 2'd2;

	// ack status codes
	localparam logic [ByteW-1:0] ST_OK        = 8'd0;
	localparam logic [ByteW-1:0] ST_DUPLICATE = 8'd1;

	// configuration register indexes
	localparam logic CFG_ACK_TIMEOUT  = 1'b0;
	localparam logic CFG_MAX_ATTEMPTS = 1'b1;

endpackage

[sv/alternating_bit_arq_sender.sv]
// Alternating-bit stop-and-wait ARQ sender controller (top level)
//
//  channel | direction | tuser            | tdata
//  s_      | in        | req_type[1:0]    | ack_seq[7:0], ack_code[15:8]
//  m_      | out       | event_kind[1:0]  | frame_seq[0], attempt_number[4:1], was_duplicate[5]
//  cfg_    | in        | -                | index 0 ack_wait_ticks, index 1 max_attempts
//
// One word per cycle while m_ is not stalled: a word is held in the input register,
// the state update and result are formed in one pass and land in the output register.
// m_tvalid rises once the result has passed from the input register into the output
// register after the s_ handshake; a word that gives no result leaves no output word.
// A stalled m_ side holds both registers and drops s_tready once the input is full.
// Reset: idle, sequence bit 0, timeout 1000 ticks, five attempts.
`include "alternating_bit_arq_sender_assert.svh"

module alternating_bit_arq_sender (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ack_seq[7:0], ack_code[15:8]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame_seq[0], attempt_number[4:1], was_duplicate[5], zero[7:6]
	output logic [1:0]  m_tuser,   // event_kind[1:0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic [abarq_pkg::TimeoutW-1:0] ack_timeout_q;
	logic [abarq_pkg::AttemptW-1:0] max_attempts_q;

	// protocol state
	logic                           awaiting_q;
	logic                           seq_bit_q;
	logic [abarq_pkg::AttemptW-1:0] attempt_q;
	logic [abarq_pkg::TimeoutW-1:0] timer_q;

	// input register
	logic                        valid_s1;
	logic [abarq_pkg::KindW-1:0] req_s1;
	logic [abarq_pkg::ByteW-1:0] seq_s1;
	logic [abarq_pkg::ByteW-1:0] status_s1;

	// output register
	logic                           out_valid_q;
	logic [abarq_pkg::KindW-1:0]    out_kind_q;
	logic                           out_seq_q;
	logic [abarq_pkg::AttemptW-1:0] out_attempt_q;
	logic                           out_dup_q;

	logic out_free, advance;

	// next state and result
	logic                           awaiting_d, seq_bit_d;
	logic [abarq_pkg::AttemptW-1:0] attempt_d;
	logic [abarq_pkg::TimeoutW-1:0] timer_d, timer_inc;
	logic                           res_valid, res_dup, res_seq;
	logic [abarq_pkg::KindW-1:0]    res_kind;
	logic [abarq_pkg::AttemptW-1:0] res_attempt;
	logic                           seq_match, do_retry;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign seq_match = (seq_s1 == {{(abarq_pkg::ByteW-1){1'b0}}, seq_bit_q});
	assign timer_inc = (timer_q == abarq_pkg::TimerMax) ? timer_q : timer_q + 16'd1;

	always_comb begin
		awaiting_d  = awaiting_q;
		seq_bit_d   = seq_bit_q;
		attempt_d   = attempt_q;
		timer_d     = timer_q;
		res_valid   = 1'b0;
		res_kind    = abarq_pkg::EV_TRANSMIT;
		res_seq     = seq_bit_q;
		res_attempt = attempt_q;
		res_dup     = 1'b0;
		do_retry    = 1'b0;
		unique case (req_s1)
			abarq_pkg::REQ_START: begin
				if (!awaiting_q) begin
					awaiting_d  = 1'b1;
					attempt_d   = 4'd1;
					timer_d     = '0;
					res_valid   = 1'b1;
					res_attempt = 4'd1;
				end
			end
			abarq_pkg::REQ_ACK: begin
				if (awaiting_q && seq_match) begin
					if (status_s1 == abarq_pkg::ST_OK ||
							status_s1 == abarq_pkg::ST_DUPLICATE) begin
						res_valid  = 1'b1;
						res_kind   = abarq_pkg::EV_DELIVERED;
						res_dup    = status_s1[0];
						seq_bit_d  = !seq_bit_q;
						awaiting_d = 1'b0;
						timer_d    = '0;
					end else begin
						do_retry = 1'b1;
					end
				end
			end
			abarq_pkg::REQ_TICK: begin
				if (awaiting_q) begin
					timer_d = timer_inc;
					if (timer_inc >= ack_timeout_q) begin
						do_retry = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (do_retry) begin
			res_valid = 1'b1;
			timer_d   = '0;
			if (attempt_q < max_attempts_q) begin
				attempt_d   = attempt_q + 4'd1;
				res_attempt = attempt_q + 4'd1;
			end else begin
				res_kind   = abarq_pkg::EV_FAILED;
				awaiting_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q  <= abarq_pkg::TimeoutReset;
			max_attempts_q <= abarq_pkg::AttemptsReset;
		end else if (cfg_we) begin
			if (cfg_index == abarq_pkg::CFG_ACK_TIMEOUT) begin
				ack_timeout_q <= cfg_data;
			end else begin
				max_attempts_q <= cfg_data[abarq_pkg::AttemptW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			seq_bit_q  <= 1'b0;
			attempt_q  <= '0;
			timer_q    <= '0;
		end else if (advance) begin
			awaiting_q <= awaiting_d;
			seq_bit_q  <= seq_bit_d;
			attempt_q  <= attempt_d;
			timer_q    <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1    <= s_tuser;
			seq_s1    <= s_tdata[7:0];
			status_s1 <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_kind_q    <= res_kind;
			out_seq_q     <= res_seq;
			out_attempt_q <= res_attempt;
			out_dup_q     <= res_dup;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_dup_q, out_attempt_q, out_seq_q};

	`ABARQ_ASSERT_NEXT(a_tx_opens_window,
		advance && res_valid && res_kind == abarq_pkg::EV_TRANSMIT, awaiting_q,
		"transmit issued but no acknowledge window open")
	`ABARQ_ASSERT_NEXT(a_done_closes_window,
		advance && res_valid && res_kind != abarq_pkg::EV_TRANSMIT, !awaiting_q,
		"delivery or failure left the window open")
	`ABARQ_ASSERT_NOW(a_attempt_nonzero, awaiting_q, attempt_q != '0,
		"window open with zero attempts")
	`ABARQ_ASSERT_NOW(a_stall_holds_input, !s_tready, valid_s1 && out_valid_q && !m_tready,
		"input stalled without a blocked output")

endmodule

[tb/tb_alternating_bit_arq_sender.sv]
// Testbench for the alternating-bit ARQ sender: predicted events checked against the stream output
`timescale 1ns / 1ps

module tb_alternating_bit_arq_sender;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned N_PHASES    = 12;
	localparam int unsigned PHASE_WORDS = 120;
	localparam int unsigned SETTLE      = 4;
	localparam logic [abarq_pkg::KindW-1:0] REQ_UNUSED = 2'd3;

	typedef logic [abarq_pkg::KindW-1:0]     kind_t;
	typedef logic [abarq_pkg::ByteW-1:0]     octet_t;
	typedef logic [abarq_pkg::AttemptW-1:0]  attempt_t;
	typedef logic [abarq_pkg::TimeoutW-1:0]  ticks_t;

	typedef struct packed {
		kind_t    kind;
		logic     seq;
		attempt_t attempt;
		logic     dup;
	} arq_event_t;

	// mirror of the sender state, one expected event per word that produces one
	class arq_event_model_t;
		ticks_t     window_limit;
		attempt_t   attempt_limit;
		bit         busy;
		bit         seq_bit;
		attempt_t   attempts;
		ticks_t     timer;
		arq_event_t pending_events[$];
		int         errors;
		int         n_sent;
		int         n_delivered;
		int         n_failed;

		function new();
			window_limit  = abarq_pkg::TimeoutReset;
			attempt_limit = abarq_pkg::AttemptsReset;
			busy          = 1'b0;
			seq_bit       = 1'b0;
			attempts      = '0;
			timer         = '0;
			errors        = 0;
			n_sent        = 0;
			n_delivered   = 0;
			n_failed      = 0;
		endfunction

		function void set_register(logic idx, logic [15:0] val);
			if (idx == abarq_pkg::CFG_ACK_TIMEOUT) begin
				window_limit = val;
			end else begin
				attempt_limit = val[abarq_pkg::AttemptW-1:0];
			end
		endfunction

		function void push_event(kind_t kind, logic dup);
			pending_events.push_back('{kind: kind, seq: seq_bit, attempt: attempts, dup: dup});
		endfunction

		function void retry_or_give_up();
			timer = '0;
			if (attempts < attempt_limit) begin
				attempts = attempts + 1'b1;
				push_event(abarq_pkg::EV_TRANSMIT, 1'b0);
			end else begin
				push_event(abarq_pkg::EV_FAILED, 1'b0);
				busy = 1'b0;
			end
		endfunction

		// returns 1 when the word moved the state or produced an event
		function bit take_request(kind_t req, octet_t seq, octet_t status);
			unique case (req)
				abarq_pkg::REQ_START: begin
					if (busy)
						return 1'b0;
					busy     = 1'b1;
					attempts = 4'd1;
					timer    = '0;
					push_event(abarq_pkg::EV_TRANSMIT, 1'b0);
					return 1'b1;
				end
				abarq_pkg::REQ_ACK: begin
					if (!busy || seq != {7'd0, seq_bit})
						return 1'b0;
					if (status == abarq_pkg::ST_OK || status == abarq_pkg::ST_DUPLICATE) begin
						push_event(abarq_pkg::EV_DELIVERED, status[0]);
						seq_bit = ~seq_bit;
						busy    = 1'b0;
						timer   = '0;
					end else begin
						retry_or_give_up();
					end
					return 1'b1;
				end
				abarq_pkg::REQ_TICK: begin
					if (!busy)
						return 1'b0;
					if (timer != abarq_pkg::TimerMax)
						timer = timer + 1'b1;
					if (timer >= window_limit)
						retry_or_give_up();
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void match_event(kind_t kind, logic [7:0] data);
			arq_event_t want;
			arq_event_t got;
			got = '{kind: kind, seq: data[0], attempt: data[4:1], dup: data[5]};
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected event kind=%0d seq=%0d attempt=%0d dup=%0d",
						got.kind, got.seq, got.attempt, got.dup);
				return;
			end
			want = pending_events.pop_front();
			if (want.kind != got.kind || want.seq != got.seq ||
					want.attempt != got.attempt || want.dup != got.dup) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: event mismatch exp kind=%0d seq=%0d attempt=%0d dup=%0d",
						want.kind, want.seq, want.attempt, want.dup);
					$display("       got kind=%0d seq=%0d attempt=%0d dup=%0d",
						got.kind, got.seq, got.attempt, got.dup);
				end
			end
			unique case (want.kind)
				abarq_pkg::EV_TRANSMIT:  n_sent++;
				abarq_pkg::EV_DELIVERED: n_delivered++;
				default:                 n_failed++;
			endcase
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // ack_seq[7:0], ack_code[15:8]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // frame_seq[0], attempt_number[4:1], was_duplicate[5]
	logic [1:0]  m_tuser;   // event_kind[1:0]
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	arq_event_model_t model = new();
	bit  tx_calm;
	bit  rx_calm;
	int  stall_left;
	int  n_requests;
	int  n_effective;
	int  n_settings;

	alternating_bit_arq_sender DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!rx_calm && $urandom_range(99) < 30) begin
			stall_left = pause_len();
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.match_event(m_tuser, m_tdata);
	end

	initial begin
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_word(input kind_t req, input octet_t seq, input octet_t status);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {status, seq};
		do @(posedge clk); while (!s_tready);
		if (model.take_request(req, seq, status))
			n_effective++;
		n_requests++;
		@(negedge clk);
	endtask

	task automatic put(input kind_t req, input octet_t seq, input octet_t status);
		int gap;
		send_word(req, seq, status);
		gap = tx_calm ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the sender until every predicted event has been taken
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (model.pending_events.size() != 0);
	endtask

	task automatic cfg_write(input logic idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		model.set_register(idx, val);
		n_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] timeout, input logic [3:0] attempts);
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		cfg_write(abarq_pkg::CFG_ACK_TIMEOUT, timeout);
		cfg_write(abarq_pkg::CFG_MAX_ATTEMPTS, {12'($urandom_range(4095)), attempts});
	endtask

	// mostly well-formed frame exchanges, with some stray and malformed words
	function automatic void pick_request(output kind_t req, output octet_t seq,
			output octet_t status);
		int r;
		r      = $urandom_range(99);
		seq    = 8'($urandom_range(255));
		status = 8'($urandom_range(255));
		if (!model.busy) begin
			if (r < 85)
				req = abarq_pkg::REQ_START;
			else
				req = 2'($urandom_range(3));
		end else if (r < 45) begin
			req = abarq_pkg::REQ_TICK;
		end else if (r < 60) begin
			req    = abarq_pkg::REQ_ACK;
			seq    = {7'd0, model.seq_bit};
			status = 8'($urandom_range(255, 2));
		end else if (r < 80) begin
			req    = abarq_pkg::REQ_ACK;
			seq    = {7'd0, model.seq_bit};
			status = $urandom_range(1) ? abarq_pkg::ST_DUPLICATE : abarq_pkg::ST_OK;
		end else if (r < 88) begin
			req = abarq_pkg::REQ_ACK;
			if (seq == {7'd0, model.seq_bit})
				seq ^= 8'h80;
		end else if (r < 93) begin
			req = abarq_pkg::REQ_START;
		end else if (r < 96) begin
			req = REQ_UNUSED;
		end else begin
			req = 2'($urandom_range(3));
		end
	endfunction

	initial begin
		int phase_timeout[N_PHASES]  = '{1, 2, 3, 65535, 0, 4, 1, 6, 2, 5, 3, 1};
		int phase_attempts[N_PHASES] = '{1, 15, 5, 15, 0, 3, 15, 2, 1, 4, 7, 10};
		kind_t  req;
		octet_t seq;
		octet_t status;
		int done;
		bit held;

		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = abarq_pkg::REQ_START;
		cfg_we      = 1'b0;
		cfg_index   = abarq_pkg::CFG_ACK_TIMEOUT;
		cfg_data    = '0;
		tx_calm     = 1'b1;
		rx_calm     = 1'b1;
		n_requests  = 0;
		n_effective = 0;
		n_settings  = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: timeout 1000, five attempts
		put(abarq_pkg::REQ_TICK, 8'hFF, 8'hFF);
		put(abarq_pkg::REQ_ACK, 8'h00, abarq_pkg::ST_OK);
		put(REQ_UNUSED, 8'h00, 8'h00);
		put(abarq_pkg::REQ_START, 8'hA5, 8'h5A);
		put(abarq_pkg::REQ_START, 8'h00, 8'h00);
		put(abarq_pkg::REQ_ACK, 8'h01, abarq_pkg::ST_OK);
		put(abarq_pkg::REQ_ACK, 8'hFF, abarq_pkg::ST_OK);
		put(abarq_pkg::REQ_ACK, 8'h00, 8'hFF);
		put(abarq_pkg::REQ_ACK, 8'h00, 8'h80);
		put(abarq_pkg::REQ_TICK, 8'h00, 8'h00);
		put(abarq_pkg::REQ_TICK, 8'hFF, 8'hFF);
		put(REQ_UNUSED, 8'hFF, 8'hFF);
		put(abarq_pkg::REQ_ACK, 8'h00, abarq_pkg::ST_DUPLICATE);
		put(abarq_pkg::REQ_START, 8'h00, 8'h00);
		put(abarq_pkg::REQ_ACK, 8'h00, abarq_pkg::ST_OK);
		put(abarq_pkg::REQ_ACK, 8'h01, abarq_pkg::ST_OK);
		put(abarq_pkg::REQ_START, 8'h00, 8'h00);
		put(abarq_pkg::REQ_ACK, 8'h00, 8'h02);

		// zero timeout and zero attempt limit: first tick expires and fails
		reconfigure(16'd0, 4'd0);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		put(abarq_pkg::REQ_TICK, 8'h00, 8'h00);
		put(abarq_pkg::REQ_START, 8'h00, 8'h00);
		put(abarq_pkg::REQ_TICK, 8'h00, 8'h00);
		put(abarq_pkg::REQ_START, 8'h00, 8'h00);
		put(abarq_pkg::REQ_ACK, 8'h00, 8'h7F);

		for (int p = 0; p < N_PHASES; p++) begin
			reconfigure(16'(phase_timeout[p]), 4'(phase_attempts[p]));
			tx_calm = (p % 4 == 1);
			rx_calm = (p % 4 == 1) || (p % 5 == 3);
			done = 0;
			held = 1'b0;
			while (done < PHASE_WORDS) begin
				pick_request(req, seq, status);
				put(req, seq, status);
				done++;
				if (done == PHASE_WORDS / 2 && !held) begin
					wait_drained();
					held = 1'b1;
				end
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);

		$display("Run: %0d request words (%0d changed state) over %0d register writes,",
			n_requests, n_effective, n_settings);
		$display("timeouts 0..65535, limits 0..15; events %0d transmit, %0d delivered, %0d failed.",
			model.n_sent, model.n_delivered, model.n_failed);
		if (model.pending_events.size() != 0)
			$display("ERROR: %0d predicted events never arrived", model.pending_events.size());
		if (model.errors == 0 && model.pending_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("Mismatches: %0d", model.errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
